>>> hw/rtl/htnc_pkg.sv
// Shared types, character constants and error codes for the tag nesting checker.
package htnc_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int NAME_LEN_DEF    = 32;
    localparam int LEN_W           = 6;
    localparam int VOID_LEN        = 4;

    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_MISMATCH  = 3'd1,
        ERR_EMPTY     = 3'd2,
        ERR_UNCLOSED  = 3'd3,
        ERR_VOID_OPEN = 3'd4,
        ERR_OVERFLOW  = 3'd5
    } t_err_code;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    // Bytes of the "img " prefix that marks a tag which is never stacked.
    function automatic logic [7:0] void_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = 8'h69;
            2'd1: b = 8'h6D;
            2'd2: b = 8'h67;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/htnc_len_cell.sv
// One cell of the length stack: holds one entry length and shifts on push or pop.
module htnc_len_cell (
    input  logic                          i_clk,
    input  htnc_pkg::t_stk_ctl            i_ctl,
    input  logic [htnc_pkg::LEN_W-1:0]    i_from_above,
    input  logic [htnc_pkg::LEN_W-1:0]    i_from_below,
    output logic [htnc_pkg::LEN_W-1:0]    o_len
);

    logic [htnc_pkg::LEN_W-1:0] r_len;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_len <= i_from_above;
        end else if (i_ctl.pop) begin
            r_len <= i_from_below;
        end
    end

    assign o_len = r_len;

endmodule

>>> hw/rtl/htnc_len_stack.sv
// Row of length cells forming a shift stack whose top entry sits in the first cell.
module htnc_len_stack #(
    parameter int STACK_DEPTH = htnc_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  htnc_pkg::t_stk_ctl            i_ctl,
    input  logic [htnc_pkg::LEN_W-1:0]    i_push_len,
    output logic [htnc_pkg::LEN_W-1:0]    o_top_len
);

    logic [htnc_pkg::LEN_W-1:0] w_len [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [htnc_pkg::LEN_W-1:0] w_above;
        logic [htnc_pkg::LEN_W-1:0] w_below;

        if (g == 0) begin : g_first
            assign w_above = i_push_len;
        end else begin : g_mid
            assign w_above = w_len[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_below = w_len[g];
        end else begin : g_next
            assign w_below = w_len[g+1];
        end

        htnc_len_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_len        (w_len[g])
        );
    end

    assign o_top_len = w_len[0];

endmodule

>>> hw/rtl/htnc_name_store.sv
// Tag name byte memory, one row per stack level, with a registered read port.
module htnc_name_store #(
    parameter int STACK_DEPTH = htnc_pkg::STACK_DEPTH_DEF,
    parameter int NAME_LEN    = htnc_pkg::NAME_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_wr_row,
    input  logic [$clog2(NAME_LEN)-1:0]    i_wr_col,
    input  logic [7:0]                     i_wr_data,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_rd_row,
    input  logic [$clog2(NAME_LEN)-1:0]    i_rd_col,
    output logic [7:0]                     o_rd_data
);

    logic [7:0] r_mem [STACK_DEPTH][NAME_LEN];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row][i_wr_col] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_row][i_rd_col];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/html_tag_nesting_checker.sv
// Top level of the markup tag nesting checker with stream input and verdict output.
// The checker takes one document byte per cycle unless stalled and holds one verdict in
// an output register that can be refilled in the cycle it drains, so the input stalls
// only while that register holds a verdict that the receiver is not taking. The
// verdict appears in the cycle after the transfer that carries the final byte. The single
// compare per byte against the open tag's stored name is what sets the rate: the memory
// read for the next byte position is issued from the next state, ahead of that byte, so
// each byte sees its stored byte ready. Entry lengths live in a shifting row of cells
// with the top entry in front.
module html_tag_nesting_checker #(
    parameter int STACK_DEPTH = htnc_pkg::STACK_DEPTH_DEF,
    parameter int NAME_LEN    = htnc_pkg::NAME_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // char_byte[7:0]
    input  logic        i_s_axis_tlast,   // doc_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // verdict[0], error_code[3:1], open_count[8:4]
);

    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam int RW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(NAME_LEN + 1);
    localparam int CW = $clog2(NAME_LEN);
    localparam int LW = htnc_pkg::LEN_W;

    logic [TW-1:0]         r_top,     n_top;
    logic                  r_inside,  n_inside;
    logic                  r_closing, n_closing;
    logic [PW-1:0]         r_pos,     n_pos;
    logic                  r_cmp,     n_cmp;
    logic                  r_void,    n_void;
    htnc_pkg::t_err_code   r_err,     n_err;

    logic                  r_out_valid;
    logic                  r_out_verdict;
    htnc_pkg::t_err_code   r_out_code;
    logic [4:0]            r_out_count;

    logic                  w_acc;
    logic                  w_out_load;
    htnc_pkg::t_err_code   w_code;
    htnc_pkg::t_stk_ctl    w_ctl;
    logic [LW-1:0]         w_push_len;
    logic [LW-1:0]         w_top_len;
    logic                  w_wr_en;
    logic [RW-1:0]         w_rd_row;
    logic [CW-1:0]         w_rd_col;
    logic [TW-1:0]         w_rd_top;
    logic [7:0]            w_rd_data;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        logic [7:0] c;
        logic       lst;
        logic       fin;
        logic       term;
        c    = i_s_axis_tdata;
        lst  = i_s_axis_tlast;
        fin  = 1'b0;
        term = 1'b0;

        n_top      = r_top;
        n_inside   = r_inside;
        n_closing  = r_closing;
        n_pos      = r_pos;
        n_cmp      = r_cmp;
        n_void     = r_void;
        n_err      = r_err;
        w_ctl      = '0;
        w_push_len = '0;
        w_wr_en    = 1'b0;
        w_out_load = 1'b0;
        w_code     = htnc_pkg::ERR_NONE;

        if (w_acc) begin
            if (r_err == htnc_pkg::ERR_NONE) begin
                if (!r_inside) begin
                    if (c == htnc_pkg::CHAR_LT) begin
                        n_inside  = 1'b1;
                        n_closing = 1'b0;
                        n_pos     = '0;
                        n_cmp     = 1'b0;
                        n_void    = 1'b1;
                    end
                end else if (c == htnc_pkg::CHAR_GT) begin
                    fin  = 1'b1;
                    term = 1'b1;
                end else if (r_pos == '0 && !r_closing && c == htnc_pkg::CHAR_SLASH) begin
                    n_closing = 1'b1;
                    n_void    = 1'b0;
                end else if (r_closing) begin
                    if (r_top == '0 || r_pos >= PW'(NAME_LEN) ||
                        LW'(r_pos) >= w_top_len || w_rd_data != c) begin
                        n_cmp = 1'b1;
                    end
                    if (r_pos < PW'(NAME_LEN)) begin
                        n_pos = r_pos + PW'(1);
                    end
                end else begin
                    if (r_pos < PW'(htnc_pkg::VOID_LEN) &&
                        c != htnc_pkg::void_byte(r_pos[1:0])) begin
                        n_void = 1'b0;
                    end
                    if (r_pos < PW'(NAME_LEN)) begin
                        w_wr_en = (r_top < TW'(STACK_DEPTH));
                        n_pos   = r_pos + PW'(1);
                    end else if (!r_void) begin
                        n_err    = htnc_pkg::ERR_OVERFLOW;
                        n_inside = 1'b0;
                    end
                end
            end

            if (lst && n_err == htnc_pkg::ERR_NONE && n_inside) begin
                fin = 1'b1;
            end

            if (fin) begin
                n_inside = 1'b0;
                if (n_closing) begin
                    if (r_top == '0) begin
                        n_err = htnc_pkg::ERR_EMPTY;
                    end else if (n_cmp) begin
                        n_err = htnc_pkg::ERR_MISMATCH;
                    end else begin
                        w_ctl.pop = 1'b1;
                        n_top     = r_top - TW'(1);
                    end
                end else if (n_void && n_pos >= PW'(htnc_pkg::VOID_LEN)) begin
                    if (!term) begin
                        n_err = htnc_pkg::ERR_VOID_OPEN;
                    end
                end else if (r_top >= TW'(STACK_DEPTH)) begin
                    n_err = htnc_pkg::ERR_OVERFLOW;
                end else begin
                    w_ctl.push = 1'b1;
                    w_push_len = LW'(n_pos);
                    n_top      = r_top + TW'(1);
                end
            end

            if (lst) begin
                w_out_load = 1'b1;
                if (n_err == htnc_pkg::ERR_NONE && n_top != '0) begin
                    w_code = htnc_pkg::ERR_UNCLOSED;
                end else begin
                    w_code = n_err;
                end
            end
        end
    end

    // The read address follows the next state so the stored byte is ready in time.
    assign w_rd_top = n_top - TW'(1);
    assign w_rd_row = (n_top == '0) ? '0 : w_rd_top[RW-1:0];
    assign w_rd_col = (n_pos >= PW'(NAME_LEN)) ? '0 : n_pos[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= '0;
            r_inside  <= 1'b0;
            r_closing <= 1'b0;
            r_pos     <= '0;
            r_cmp     <= 1'b0;
            r_void    <= 1'b0;
            r_err     <= htnc_pkg::ERR_NONE;
        end else if (w_out_load) begin
            r_top     <= '0;
            r_inside  <= 1'b0;
            r_closing <= 1'b0;
            r_pos     <= '0;
            r_cmp     <= 1'b0;
            r_void    <= 1'b0;
            r_err     <= htnc_pkg::ERR_NONE;
        end else begin
            r_top     <= n_top;
            r_inside  <= n_inside;
            r_closing <= n_closing;
            r_pos     <= n_pos;
            r_cmp     <= n_cmp;
            r_void    <= n_void;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_verdict <= (w_code != htnc_pkg::ERR_NONE);
            r_out_code    <= w_code;
            r_out_count   <= 5'(n_top);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_count, r_out_code, r_out_verdict};

    htnc_len_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_len_stack (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_push_len (w_push_len),
        .o_top_len  (w_top_len)
    );

    htnc_name_store #(
        .STACK_DEPTH (STACK_DEPTH),
        .NAME_LEN    (NAME_LEN)
    ) u_name_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_row  (r_top[RW-1:0]),
        .i_wr_col  (r_pos[CW-1:0]),
        .i_wr_data (i_s_axis_tdata),
        .i_rd_row  (w_rd_row),
        .i_rd_col  (w_rd_col),
        .o_rd_data (w_rd_data)
    );

    a_top_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_clear_after_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_s_axis_tlast |=> r_top == '0 && !r_inside && r_err == htnc_pkg::ERR_NONE)
        else $error("state not cleared after final byte");

    a_error_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != htnc_pkg::ERR_NONE && !(w_acc && i_s_axis_tlast) |=> r_err == $past(r_err))
        else $error("first error changed before document end");

    a_verdict_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_verdict == (r_out_code != htnc_pkg::ERR_NONE))
        else $error("verdict disagrees with error code");

    a_push_pop_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.push && w_ctl.pop))
        else $error("conflicting stack operations in one cycle");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the tag nesting checker: byte documents in, verdicts checked.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STK            = htnc_pkg::STACK_DEPTH_DEF;
    localparam int NML            = htnc_pkg::NAME_LEN_DEF;
    localparam int HALF_PERIOD    = 6;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 10;
    localparam logic [31:0] IMG_WORD = "img ";

    typedef struct {
        logic                verdict;
        htnc_pkg::t_err_code code;
        logic [4:0]          open_count;
    } t_verdict;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;

    html_tag_nesting_checker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Predictor state: the open-tag stack and the tag being parsed.
    logic [7:0]          open_names [STK][NML];
    int                  open_lens [STK];
    int                  depth      = 0;
    bit                  in_tag     = 1'b0;
    bit                  closing    = 1'b0;
    int                  pos        = 0;
    bit                  cmp_bad    = 1'b0;
    bit                  img_prefix = 1'b0;
    htnc_pkg::t_err_code first_err  = htnc_pkg::ERR_NONE;

    t_verdict   expected_verdicts [$];
    int         mismatches     = 0;
    int         bytes_sent     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_reqs      = 0;
    int         hold_done      = 0;
    int         hold_left      = 0;
    int         quiet_cycles   = 0;

    // Document under construction and the stimulus-side view of its open tags.
    logic [7:0] doc_q [$];
    logic [7:0] gen_names [STK][64];
    int         gen_lens [STK];
    int         gen_sp;

    function automatic void flag_error(htnc_pkg::t_err_code c);
        if (first_err == htnc_pkg::ERR_NONE) first_err = c;
        in_tag = 1'b0;
    endfunction

    function automatic void take_tag_byte(logic [7:0] c);
        if (pos == 0 && !closing && c == htnc_pkg::CHAR_SLASH) begin
            closing    = 1'b1;
            img_prefix = 1'b0;
        end else if (closing) begin
            if (depth == 0 || pos >= open_lens[depth-1] || pos >= NML
                || open_names[depth-1][pos] != c) cmp_bad = 1'b1;
            if (pos < NML) pos++;
        end else begin
            if (pos < htnc_pkg::VOID_LEN && c != IMG_WORD[31 - 8*pos -: 8])
                img_prefix = 1'b0;
            if (pos < NML) begin
                if (depth < STK) open_names[depth][pos] = c;
                pos++;
            end else if (!img_prefix) begin
                flag_error(htnc_pkg::ERR_OVERFLOW);
            end
        end
    endfunction

    function automatic void close_tag(bit terminated);
        in_tag = 1'b0;
        if (closing) begin
            if (depth == 0) flag_error(htnc_pkg::ERR_EMPTY);
            else if (cmp_bad) flag_error(htnc_pkg::ERR_MISMATCH);
            else depth--;
        end else if (img_prefix && pos >= htnc_pkg::VOID_LEN) begin
            if (!terminated) flag_error(htnc_pkg::ERR_VOID_OPEN);
        end else if (depth >= STK) begin
            flag_error(htnc_pkg::ERR_OVERFLOW);
        end else begin
            open_lens[depth] = pos;
            depth++;
        end
    endfunction

    function automatic bit predict_byte(input logic [7:0] c, input bit is_end,
                                        output t_verdict v);
        htnc_pkg::t_err_code err;
        v = '{1'b0, htnc_pkg::ERR_NONE, 5'd0};
        if (first_err == htnc_pkg::ERR_NONE) begin
            if (!in_tag) begin
                if (c == htnc_pkg::CHAR_LT) begin
                    in_tag     = 1'b1;
                    closing    = 1'b0;
                    pos        = 0;
                    cmp_bad    = 1'b0;
                    img_prefix = 1'b1;
                end
            end else if (c == htnc_pkg::CHAR_GT) begin
                close_tag(1'b1);
            end else begin
                take_tag_byte(c);
            end
        end
        if (!is_end) return 1'b0;
        if (first_err == htnc_pkg::ERR_NONE && in_tag) close_tag(1'b0);
        err = first_err;
        if (err == htnc_pkg::ERR_NONE && depth != 0) err = htnc_pkg::ERR_UNCLOSED;
        v.verdict    = (err != htnc_pkg::ERR_NONE);
        v.code       = err;
        v.open_count = 5'(depth);
        depth      = 0;
        in_tag     = 1'b0;
        closing    = 1'b0;
        pos        = 0;
        cmp_bad    = 1'b0;
        img_prefix = 1'b0;
        first_err  = htnc_pkg::ERR_NONE;
        return 1'b1;
    endfunction

    function automatic void report_field(string field, int unsigned want, int unsigned got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_verdict fresh;
        t_verdict want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t ns: unexpected verdict transfer, expected none, actual 0x%0h",
                             $time, o_m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_m_axis_tdata[0] !== want.verdict)
                        report_field("verdict", want.verdict, o_m_axis_tdata[0]);
                    if (o_m_axis_tdata[3:1] !== want.code)
                        report_field("error_code", want.code, o_m_axis_tdata[3:1]);
                    if (o_m_axis_tdata[8:4] !== want.open_count)
                        report_field("open_count", want.open_count, o_m_axis_tdata[8:4]);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (predict_byte(i_s_axis_tdata, i_s_axis_tlast, fresh))
                    expected_verdicts.push_back(fresh);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_reqs != hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = hold_reqs;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL html_tag_nesting_checker");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, bit is_end);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= is_end;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
    endtask

    task automatic wait_verdicts_drained();
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;
        @(negedge i_clk);
        while (expected_verdicts.size() != 0) @(negedge i_clk);
    endtask

    function automatic void add_byte(logic [7:0] b);
        doc_q.push_back(b);
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
    endfunction

    task automatic run_str(string s);
        doc_q.delete();
        add_str(s);
        send_doc();
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == htnc_pkg::CHAR_LT);
        return b;
    endfunction

    function automatic logic [7:0] name_byte(bit first);
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 9) < 7) b = 8'($urandom_range(8'h61, 8'h7A));
            else b = 8'($urandom_range(0, 255));
        end while (b == htnc_pkg::CHAR_GT || (first && b == htnc_pkg::CHAR_SLASH));
        return b;
    endfunction

    function automatic void gen_text(int n);
        repeat (n) add_byte(text_byte());
    endfunction

    function automatic void gen_open(int n);
        logic [7:0] b;
        add_byte(htnc_pkg::CHAR_LT);
        for (int i = 0; i < n; i++) begin
            b = name_byte(i == 0);
            add_byte(b);
            if (gen_sp < STK) gen_names[gen_sp][i] = b;
        end
        add_byte(htnc_pkg::CHAR_GT);
        if (gen_sp < STK) gen_lens[gen_sp] = n;
        gen_sp++;
    endfunction

    function automatic void gen_close(bit exact);
        int n;
        int keep;
        add_byte(htnc_pkg::CHAR_LT);
        add_byte(htnc_pkg::CHAR_SLASH);
        if (gen_sp > 0 && gen_sp <= STK) begin
            n    = gen_lens[gen_sp-1];
            keep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n;
            for (int i = 0; i < keep; i++) add_byte(gen_names[gen_sp-1][i]);
        end
        if (!exact || gen_sp == 0) add_byte(name_byte(1'b0));
        add_byte(htnc_pkg::CHAR_GT);
        if (gen_sp > 0) gen_sp--;
    endfunction

    function automatic void gen_img(int n, bit terminated);
        add_str("<img ");
        repeat (n) add_byte(name_byte(1'b0));
        if (terminated) add_byte(htnc_pkg::CHAR_GT);
    endfunction

    function automatic int pick_name_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return htnc_pkg::CHAR_LT;
            1: return htnc_pkg::CHAR_GT;
            2: return htnc_pkg::CHAR_SLASH;
            3: return IMG_WORD[31:24];
            4: return IMG_WORD[23:16];
            5: return IMG_WORD[15:8];
            6: return IMG_WORD[7:0];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed nesting with random names; the rest is broken or pure noise.
    function automatic void build_random_doc();
        int kind;
        int steps;
        int r;
        doc_q.delete();
        gen_sp = 0;
        kind   = $urandom_range(0, 99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 20)) add_byte(noise_byte());
        end else begin
            steps = ($urandom_range(0, 24) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 7);
            repeat (steps) begin
                r = $urandom_range(0, 99);
                if (r < 15) gen_text($urandom_range(1, 4));
                else if (r < 55) gen_open(pick_name_len());
                else if (r < 65) gen_img($urandom_range(0, 5), 1'b1);
                else if (gen_sp > 0) gen_close(1'b1);
                else gen_text(1);
            end
            if (kind < 70) begin
                while (gen_sp > 0) gen_close(1'b1);
                if ($urandom_range(0, 1)) gen_text($urandom_range(1, 3));
            end else begin
                case (kind % 5)
                    0: ;
                    1: begin
                        while (gen_sp > 0) gen_close(1'b1);
                        gen_close(1'b1);
                    end
                    2: gen_close(1'b0);
                    3: gen_img($urandom_range(0, 4), 1'b0);
                    default: begin
                        add_byte(htnc_pkg::CHAR_LT);
                        repeat ($urandom_range(0, 3)) add_byte(name_byte(1'b0));
                    end
                endcase
            end
        end
        if (doc_q.size() == 0) gen_text(1);
    endfunction

    task automatic test_tag_matching();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_str("<a></a>");
        run_str("<></>");
        run_str("<ab></>");
        run_str("<abc></ab>");
        run_str("<a<b></a<b>");
        run_str("<a/b></a/b>");
        run_str("<img x>");
        run_str("<im></im>");
        run_str("<img>");
        run_str("text > only");
        run_str("<p>x</p>tail");
        doc_q.delete();
        add_byte(htnc_pkg::CHAR_LT);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(htnc_pkg::CHAR_GT);
        add_str("</");
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(htnc_pkg::CHAR_GT);
        send_doc();
        wait_verdicts_drained();
    endtask

    task automatic test_error_codes();
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        run_str("</a>");
        run_str("<ab></abc>");
        run_str("<ab></ax>");
        run_str("<a><b>");
        run_str("</x><a>");
        run_str("<a></b><c>");
        wait_verdicts_drained();
    endtask

    task automatic test_end_inside_tag();
        send_idle_pct  = 57;
        recv_stall_pct = 0;
        run_str("<");
        run_str("a");
        run_str("<ab");
        run_str("x<");
        run_str("<img x");
        run_str("<img");
        run_str("<a></a");
        run_str("</");
        run_str("<a><img ");
        wait_verdicts_drained();
    endtask

    task automatic test_stack_and_name_limits();
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        doc_q.delete();
        repeat (STK) add_str("<>");
        add_str("<>");
        send_doc();
        doc_q.delete();
        repeat (STK) add_str("<>");
        add_str("<img >");
        send_doc();
        doc_q.delete();
        add_byte(htnc_pkg::CHAR_LT);
        repeat (NML) add_byte("x");
        add_str("></");
        repeat (NML) add_byte("x");
        add_byte(htnc_pkg::CHAR_GT);
        send_doc();
        doc_q.delete();
        add_byte(htnc_pkg::CHAR_LT);
        repeat (NML + 1) add_byte("y");
        add_byte(htnc_pkg::CHAR_GT);
        send_doc();
        doc_q.delete();
        add_str("<img ");
        repeat (NML) add_byte("z");
        add_str("><img ");
        send_doc();
        wait_verdicts_drained();
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < 20) begin
            build_random_doc();
            send_doc();
        end
        wait_verdicts_drained();
    endtask

    task automatic test_random_documents();
        run_random_phase(0, 0);
        run_random_phase(57, 0);
        run_random_phase(0, 57);
        run_random_phase(37, 37);
    endtask

    // The receiver holds off while short documents keep coming, so the verdict register fills.
    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_reqs++;
        repeat (6) begin
            doc_q.delete();
            add_str("<q>");
            if ($urandom_range(0, 1)) add_str("</q>");
            send_doc();
        end
        wait_verdicts_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_tag_matching();
        test_error_codes();
        test_end_inside_tag();
        test_stack_and_name_limits();
        test_random_documents();
        test_output_hold_off();
        wait_verdicts_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS html_tag_nesting_checker");
        end else begin
            $display("FAIL html_tag_nesting_checker");
        end
        $finish;
    end

endmodule
